FILE: rtl/core/swt_pkg.sv
// shared types and constants of the sensor watch table
package swt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int SENSORS_DEF = 32;
    localparam int MAX_RESULTS = 16;

    localparam int ID_W   = 4;
    localparam int SIDX_W = 5;
    localparam int BITS_W = 32;
    localparam int KIND_W = 2;
    localparam int SLOT_W = 4;

    localparam logic OP_SUB  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_W-1:0] K_SUB    = 2'd0;
    localparam logic [KIND_W-1:0] K_FULL   = 2'd1;
    localparam logic [KIND_W-1:0] K_NOTIFY = 2'd2;
    localparam logic [KIND_W-1:0] K_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              start;
        logic              step;
        logic              op;
        logic              fire_en;
        logic [ID_W-1:0]   id;
        logic [SIDX_W-1:0] sidx;
        logic              lvl;
        logic [BITS_W-1:0] bits;
    } t_cell_ctl;

endpackage

FILE: rtl/core/swt_cell.sv
// one watch slot of the chain, examined when the scan token sits here
module swt_cell
    import swt_pkg::*;
#(
    parameter int SENSORS = SENSORS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic            i_head,
    input  logic            i_tok,
    output logic            o_tok,
    output logic            o_hit,
    output logic [ID_W-1:0] o_id
);

    logic              r_tok;
    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [SIDX_W-1:0] r_sidx;
    logic              r_lvl;
    logic              n_tok;
    logic              n_valid;
    logic              level;
    logic              hit;

    // sensors past the configured count read as low
    always_comb begin
        if (32'(r_sidx) < SENSORS) begin
            level = i_ctl.bits[r_sidx];
        end else begin
            level = 1'b0;
        end
    end

    always_comb begin
        if (i_ctl.op == OP_SUB) begin
            hit = r_tok && !r_valid;
        end else begin
            hit = r_tok && r_valid && (level != r_lvl) && i_ctl.fire_en;
        end
    end

    always_comb begin
        n_tok   = r_tok;
        n_valid = r_valid;
        if (i_ctl.start) begin
            n_tok = i_head;
        end else if (i_ctl.step) begin
            n_tok = i_tok;
            if (hit) begin
                n_valid = (i_ctl.op == OP_SUB);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_tok   <= n_tok;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && hit && i_ctl.op == OP_SUB) begin
            r_id   <= i_ctl.id;
            r_sidx <= i_ctl.sidx;
            r_lvl  <= i_ctl.lvl;
        end
    end

    assign o_tok = r_tok;
    assign o_hit = hit;
    assign o_id  = hit ? r_id : '0;

endmodule

FILE: rtl/core/swt_ctrl.sv
// scan sequencer, pending notify holder and output register
module swt_ctrl
    import swt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_opcode,
    input  logic [ID_W-1:0]            i_notify_id,
    input  logic [SIDX_W-1:0]          i_sensor_index,
    input  logic                       i_expected_level,
    input  logic [BITS_W-1:0]          i_sensor_bits,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [KIND_W-1:0]          o_kind,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [ID_W-1:0]            o_fired_id,
    output logic                       o_last,
    output t_cell_ctl                  o_ctl,
    input  logic [SLOTS-1:0]           i_hit,
    input  logic [SLOTS-1:0][ID_W-1:0] i_ids
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(MAX_RESULTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state            r_state;
    t_state            n_state;
    logic              r_op;
    logic [ID_W-1:0]   r_nid;
    logic [SIDX_W-1:0] r_sidx;
    logic              r_lvl;
    logic [BITS_W-1:0] r_bits;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_cnt;
    logic              r_pend_v;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [ID_W-1:0]   r_pend_id;
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [SLOT_W-1:0] r_slot;
    logic [ID_W-1:0]   r_fid;
    logic              r_last;

    logic              start;
    logic              out_free;
    logic              step;
    logic              at_end;
    logic              any_hit;
    logic [ID_W-1:0]   hit_id;
    logic [31:0]       idx_ext;
    logic [SLOT_W-1:0] idx_slot;
    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [SLOT_W-1:0] e_slot;
    logic [ID_W-1:0]   e_id;
    logic              e_last;
    logic              pend_load;
    logic              pend_clr;

    assign o_stall  = (r_state != ST_IDLE);
    assign start    = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign step     = (r_state == ST_SCAN) && out_free;
    assign at_end   = (r_idx == LAST_IDX);
    assign idx_ext  = 32'(r_idx);
    assign idx_slot = idx_ext[SLOT_W-1:0];

    // at most one cell holds the token, so a plain or collects its answer
    always_comb begin
        any_hit = 1'b0;
        hit_id  = '0;
        for (int k = 0; k < SLOTS; k++) begin
            any_hit = any_hit | i_hit[k];
            hit_id  = hit_id | i_ids[k];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (r_op == OP_SUB) begin
                        if (any_hit || at_end) begin
                            n_state = ST_IDLE;
                        end
                    end else if (at_end) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        emit      = 1'b0;
        e_kind    = K_SUB;
        e_slot    = '0;
        e_id      = '0;
        e_last    = 1'b0;
        pend_load = 1'b0;
        pend_clr  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                pend_clr = start;
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (r_op == OP_SUB) begin
                        if (any_hit) begin
                            emit   = 1'b1;
                            e_kind = K_SUB;
                            e_slot = idx_slot;
                            e_last = 1'b1;
                        end else if (at_end) begin
                            emit   = 1'b1;
                            e_kind = K_FULL;
                            e_last = 1'b1;
                        end
                    end else if (any_hit) begin
                        // a new fire pushes the previous one out, not last
                        pend_load = 1'b1;
                        emit      = r_pend_v;
                        e_kind    = K_NOTIFY;
                        e_slot    = r_pend_slot;
                        e_id      = r_pend_id;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_last   = 1'b1;
                    pend_clr = 1'b1;
                    if (r_pend_v) begin
                        e_kind = K_NOTIFY;
                        e_slot = r_pend_slot;
                        e_id   = r_pend_id;
                    end else begin
                        e_kind = K_EMPTY;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pend_load) begin
                r_pend_v <= 1'b1;
            end else if (pend_clr) begin
                r_pend_v <= 1'b0;
            end
            if (start) begin
                r_idx <= '0;
                r_cnt <= '0;
            end else begin
                if (step) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (pend_load) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op   <= i_opcode;
            r_nid  <= i_notify_id;
            r_sidx <= i_sensor_index;
            r_lvl  <= i_expected_level;
            r_bits <= i_sensor_bits;
        end
        if (pend_load) begin
            r_pend_slot <= idx_slot;
            r_pend_id   <= hit_id;
        end
        if (emit) begin
            r_kind <= e_kind;
            r_slot <= e_slot;
            r_fid  <= e_id;
            r_last <= e_last;
        end
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.start   = start;
        o_ctl.step    = step;
        o_ctl.op      = r_op;
        o_ctl.fire_en = (32'(r_cnt) < MAX_RESULTS);
        o_ctl.id      = r_nid;
        o_ctl.sidx    = r_sidx;
        o_ctl.lvl     = r_lvl;
        o_ctl.bits    = r_bits;
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_slot     = r_slot;
    assign o_fired_id = r_fid;
    assign o_last     = r_last;

endmodule

FILE: rtl/core/sensor_watch_table_top.sv
// sensor watch table: a chain of slot cells walked by a scan token
// a new item is accepted only while idle, and o_stall holds until its answer is registered;
// the token steps one slot cell per cycle while the output register is not stalled
// reset: synchronous active-low i_rst_n empties every slot and clears the output valid flag
module sensor_watch_table_top
    import swt_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int SENSORS = SENSORS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_notify_id,
    input  logic [SIDX_W-1:0] i_sensor_index,
    input  logic              i_expected_level,
    input  logic [BITS_W-1:0] i_sensor_bits,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [SLOT_W-1:0] o_slot,
    output logic [ID_W-1:0]   o_fired_id,
    output logic              o_last
);

    t_cell_ctl                  ctl;
    logic [SLOTS-1:0]           tok;
    logic [SLOTS-1:0]           hit;
    logic [SLOTS-1:0][ID_W-1:0] ids;

    swt_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_notify_id     (i_notify_id),
        .i_sensor_index  (i_sensor_index),
        .i_expected_level(i_expected_level),
        .i_sensor_bits   (i_sensor_bits),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_slot          (o_slot),
        .o_fired_id      (o_fired_id),
        .o_last          (o_last),
        .o_ctl           (ctl),
        .i_hit           (hit),
        .i_ids           (ids)
    );

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        logic tok_in;
        if (k == 0) begin : g_head
            assign tok_in = 1'b0;
        end else begin : g_link
            assign tok_in = tok[k-1];
        end

        swt_cell #(
            .SENSORS(SENSORS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl),
            .i_head (k == 0),
            .i_tok  (tok_in),
            .o_tok  (tok[k]),
            .o_hit  (hit[k]),
            .o_id   (ids[k])
        );
    end

endmodule
